@@ src/opspan_pkg.sv @@
// Package for the online price span engine: stack entry type, cell control
// struct and controller state type. Has no dependencies.
`default_nettype none

package opspan_pkg;

    localparam int unsigned PRICE_W = 31;
    localparam int unsigned INDEX_W = 32;

    // One stack entry as held by a cell.
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [INDEX_W-1:0] index;
    } entry_t;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic pop;   // every entry moves one cell toward the top
        logic push;  // every entry moves one cell toward the bottom
    } cell_ctrl_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } state_t;

endpackage

`default_nettype wire

@@ src/opspan_cell.sv @@
// One cell of the stack chain: holds a single (price, index) entry.
// Depends on opspan_pkg for the entry and control types.
`default_nettype none

module opspan_cell (
    input  wire logic                   clk,
    input  wire opspan_pkg::cell_ctrl_t ctrl,
    input  wire opspan_pkg::entry_t     from_above,
    input  wire opspan_pkg::entry_t     from_below,
    output opspan_pkg::entry_t          entry
);

    opspan_pkg::entry_t entry_reg;
    opspan_pkg::entry_t entry_next;

    // A pop takes the neighbor below, a push takes the neighbor above.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = from_below;
        end
        else if (ctrl.push)
        begin
            entry_next = from_above;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

@@ src/online_price_span_top.sv @@
// Top level of the online price span engine: controller, counters and the
// chain of stack cells. Depends on opspan_pkg and opspan_cell.
//
// Usage. Prices enter on the input channel (in_valid, in_stall, price) and
// one result per price leaves on the output channel (out_valid, out_stall,
// span, inexact). A transaction completes on a rising edge where valid is
// high and stall is low.
//
// Flow. The stack lives in a chain of cells with the top entry in cell 0.
// After a price is accepted, the controller compares it against the top
// cell once per cycle; each entry at or below the price is popped by shifting
// the whole chain one cell toward the top. The cycle that finds a higher top
// (or an empty stack) forms the span, loads the output register and pushes
// the new entry by shifting the chain one cell toward the bottom. A result
// thus appears in the output register with the push, and the next price is
// taken once the controller is back in idle. Each entry is popped at most
// once.
//
// Stalls. The output register holds a finished result while the next price is
// accepted and popped; only the final push cycle waits for a free output.
// Reset empties the stack, zeroes the day counter, sets the left boundary to
// minus one and clears the inexact flag. No clearing pass is needed, since
// cells beyond the stack count are never read.
`default_nettype none

module online_price_span_top #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [30:0] price,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      span,
    output logic             inexact
);

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    // Controller and bookkeeping state.
    opspan_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [31:0]         day_reg, day_next;
    logic [31:0]         lb_reg, lb_next;
    logic                flag_reg, flag_next;
    logic [30:0]         price_reg, price_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         span_reg, span_next;
    logic                inexact_reg, inexact_next;

    opspan_pkg::cell_ctrl_t ctrl;
    opspan_pkg::entry_t     cell_q [STACK_DEPTH];
    opspan_pkg::entry_t     new_entry;

    logic        stack_empty;
    logic        stack_full;
    logic        top_hit;
    logic        out_free;
    logic [31:0] ref_index;
    logic [31:0] span_diff;

    // The chain of cells. Cell 0 is the top of the stack; the bottom cell
    // shifts its entry out when a push finds the stack full.
    assign new_entry.price = price_reg;
    assign new_entry.index = day_reg;

    for (genvar g = 0; g < STACK_DEPTH; g++)
    begin : g_cell
        opspan_pkg::entry_t above;
        opspan_pkg::entry_t below;

        if (g == 0)
        begin : g_top
            assign above = new_entry;
        end
        else
        begin : g_mid_above
            assign above = cell_q[g-1];
        end

        if (g == STACK_DEPTH - 1)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_mid_below
            assign below = cell_q[g+1];
        end

        opspan_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .from_above (above),
            .from_below (below),
            .entry      (cell_q[g])
        );
    end

    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign top_hit     = !stack_empty && (cell_q[0].price <= price_reg);
    assign out_free    = !out_valid_reg || !out_stall;

    // The span refers to the entry left on top, or to the left boundary
    // once the stack has been emptied. A zero difference means the true
    // span wrapped a full index period, which saturates.
    assign ref_index = stack_empty ? lb_reg : cell_q[0].index;
    assign span_diff = day_reg - ref_index;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        day_next       = day_reg;
        lb_next        = lb_reg;
        flag_next      = flag_reg;
        price_next     = price_reg;
        span_next      = span_reg;
        inexact_next   = inexact_reg;
        ctrl           = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            opspan_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    price_next = price;
                    state_next = opspan_pkg::ST_SEARCH;
                end
            end
            opspan_pkg::ST_SEARCH:
            begin
                if (top_hit)
                begin
                    ctrl.pop   = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else if (out_free)
                begin
                    ctrl.push      = 1'b1;
                    out_valid_next = 1'b1;
                    span_next      = (span_diff == '0) ? '1 : span_diff;
                    day_next       = day_reg + 1'b1;
                    if (stack_full)
                    begin
                        // The oldest entry falls off the bottom of the chain.
                        lb_next      = cell_q[STACK_DEPTH-1].index;
                        flag_next    = 1'b1;
                        inexact_next = 1'b1;
                    end
                    else
                    begin
                        count_next   = count_reg + 1'b1;
                        inexact_next = flag_reg;
                    end
                    state_next = opspan_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = opspan_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= opspan_pkg::ST_IDLE;
            count_reg     <= '0;
            day_reg       <= '0;
            lb_reg        <= '1;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            day_reg       <= day_next;
            lb_reg        <= lb_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg   <= price_next;
        span_reg    <= span_next;
        inexact_reg <= inexact_next;
    end

    assign out_valid = out_valid_reg;
    assign span      = span_reg;
    assign inexact   = inexact_reg;

endmodule

`default_nettype wire

@@ tb/online_price_span_checker.sv @@
// Checker for the online price span engine: watches both channels, predicts
// each span with its own monotonic stack and compares every result.
// Depends on nothing but the port widths of online_price_span_top.
`default_nettype none

module online_price_span_checker #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [30:0] price,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] span,
    input  wire logic        inexact,
    output int               pending,
    output int               errors,
    output int               checked,
    output logic             overflowed
);

    typedef struct packed {
        logic [31:0] span;
        logic        inexact;
    } span_result_t;

    span_result_t expected_spans[$];

    // Model stack: entry 0 is the oldest (bottom) entry.
    logic [30:0] held_price [STACK_DEPTH];
    logic [31:0] held_day   [STACK_DEPTH];
    int unsigned held_count;
    logic [31:0] next_day;
    logic [32:0] left_edge;
    logic        dropped;
    int          error_total;
    int          check_total;

    function automatic span_result_t predict_span(input logic [30:0] p);
        span_result_t r;
        logic [31:0]  anchor;
        while (held_count > 0 && held_price[held_count-1] <= p)
            held_count--;
        anchor = (held_count > 0) ? held_day[held_count-1] : left_edge[31:0];
        r.span = next_day - anchor;
        if (r.span == '0)
            r.span = '1;
        if (held_count >= STACK_DEPTH)
        begin
            // Full stack: the oldest entry leaves and becomes the left edge.
            left_edge = {1'b0, held_day[0]};
            for (int i = 0; i < STACK_DEPTH - 1; i++)
            begin
                held_price[i] = held_price[i+1];
                held_day[i]   = held_day[i+1];
            end
            held_count = STACK_DEPTH - 1;
            dropped    = 1'b1;
        end
        held_price[held_count] = p;
        held_day[held_count]   = next_day;
        held_count++;
        next_day++;
        r.inexact = dropped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        span_result_t want;
        logic         bad;
        if (!rst_n)
        begin
            held_count  = 0;
            next_day    = '0;
            left_edge   = '1;
            dropped     = 1'b0;
            error_total = 0;
            check_total = 0;
            expected_spans.delete();
        end
        else
        begin
            // Results are checked before the new transaction is predicted, so
            // a result can never be matched against a price of the same edge.
            if (out_valid && !out_stall)
            begin
                if (expected_spans.size() == 0)
                begin
                    $error("unexpected result: span %0d inexact %0b", span, inexact);
                    error_total++;
                end
                else
                begin
                    want = expected_spans.pop_front();
                    bad  = 1'b0;
                    if (span !== want.span)
                    begin
                        $error("span mismatch: expected %0d, actual %0d", want.span, span);
                        bad = 1'b1;
                    end
                    if (inexact !== want.inexact)
                    begin
                        $error("inexact mismatch: expected %0b, actual %0b",
                               want.inexact, inexact);
                        bad = 1'b1;
                    end
                    if (bad)
                        error_total++;
                    check_total++;
                end
            end
            if (in_valid && !in_stall)
                expected_spans.push_back(predict_span(price));
        end
        pending    <= expected_spans.size();
        errors     <= error_total;
        checked    <= check_total;
        overflowed <= dropped;
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Top of the online price span testbench: clock, reset, price stimulus,
// receiver stalls and the verdict. Depends on online_price_span_top and
// online_price_span_checker.
`default_nettype none

module testbench;

    localparam int unsigned STACK_DEPTH  = 64;
    localparam int          RANDOM_ITEMS = 1540;
    // Worst case per price is popping a full stack and the push, plus a sender gap
    // and a receiver stall; the cycle limit is many times the slowest correct run.
    localparam int          CYCLE_LIMIT  = 1000000;
    // The longest time from acceptance to result is spent popping every stack
    // entry and then pushing, so this settles every straggler.
    localparam int          SETTLE       = 2 * STACK_DEPTH + 20;
    localparam logic [30:0] PRICE_MAX    = 31'h7FFFFFFF;

    // Shapes of random stimulus. Most are well-formed runs that build up or
    // tear down the stack; the noise shape fires fully random prices.
    typedef enum int {
        SHAPE_FALL,
        SHAPE_FALL_DEEP,
        SHAPE_RISE,
        SHAPE_TIES,
        SHAPE_ZIGZAG,
        SHAPE_NOISE,
        SHAPE_DRAIN
    } shape_t;

    // Receiver behavior, changed every so often.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURST
    } stall_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [30:0] price     = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] span;
    logic        inexact;

    int          pending;
    int          errors;
    int          checked;
    logic        overflowed;

    int          sent       = 0;
    int          burst_left = 0;
    int          cycles     = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;

    online_price_span_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .price    (price),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .span     (span),
        .inexact  (inexact)
    );

    online_price_span_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) span_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .price     (price),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .span      (span),
        .inexact   (inexact),
        .pending   (pending),
        .errors    (errors),
        .checked   (checked),
        .overflowed(overflowed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver switches between stall patterns at random intervals, so
    // results meet no stall, occasional stalls, mostly stalls and long stall
    // runs, in every phase of the block's work.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_BURST));
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    // Offers one price and holds it until the transaction completes. The
    // sender works in bursts; between bursts it drops valid for a random
    // gap. A gap of zero keeps valid high, so valid is never lowered and
    // raised again within one time step.
    task automatic send_price(input logic [30:0] p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        price    <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Holds the sender off until every expected span has come back. The
    // first edge lets the checker's count catch up with the last transaction.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [30:0] directed_prices[];
        logic [30:0] p;
        logic [30:0] step;
        shape_t      shape;
        int          run_len;
        int          random_sent;

        directed_prices = '{
            31'd0, 31'd0, PRICE_MAX, PRICE_MAX, 31'd5, 31'd4, 31'd3, 31'd2,
            31'd1, 31'd3, 31'h7FFFFFFE, 31'd0, PRICE_MAX, 31'd1, 31'h40000000,
            31'h2AAAAAAA, 31'h55555555, 31'd0, 31'd7, 31'd7
        };

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the price extremes, equal prices (which pop), a
        // falling run with spans of one, a rise that pops part of it, and a maximum
        // price that empties the stack so the span runs back to the start.
        foreach (directed_prices[i])
            send_price(directed_prices[i]);
        wait_for_drain();

        // A falling run six longer than the stack forces the first overflow,
        // then a maximum price pops everything back to the new left edge.
        p = PRICE_MAX - 31'd10;
        for (int i = 0; i < STACK_DEPTH + 6; i++)
        begin
            send_price(p);
            p = p - 31'($urandom_range(1, 1000));
        end
        send_price(PRICE_MAX);
        wait_for_drain();

        random_sent = sent;
        while (sent - random_sent < RANDOM_ITEMS)
        begin
            shape = shape_t'($urandom_range(SHAPE_FALL, SHAPE_DRAIN));
            case (shape)
                SHAPE_FALL, SHAPE_FALL_DEEP:
                begin
                    // Falling prices grow the stack; a step of zero gives ties.
                    run_len = (shape == SHAPE_FALL_DEEP) ? $urandom_range(60, 90)
                                                          : $urandom_range(4, 40);
                    p = 31'($urandom());
                    if (p < 31'h1000000)
                        p = p | 31'h40000000;
                    for (int i = 0; i < run_len; i++)
                    begin
                        send_price(p);
                        step = ($urandom_range(0, 5) == 0) ? 31'd0
                                                           : 31'($urandom_range(1, 5000));
                        p = (p > step) ? p - step : 31'd0;
                    end
                    // Often finish with a price that pops much or all of it.
                    if ($urandom_range(0, 1) == 0)
                        send_price(($urandom_range(0, 2) == 0) ? PRICE_MAX : 31'($urandom()));
                end
                SHAPE_RISE:
                begin
                    run_len = $urandom_range(3, 30);
                    p = 31'($urandom_range(0, 1000));
                    for (int i = 0; i < run_len; i++)
                    begin
                        send_price(p);
                        step = 31'($urandom_range(0, 1 << $urandom_range(0, 24)));
                        p = (PRICE_MAX - p > step) ? p + step : PRICE_MAX;
                    end
                end
                SHAPE_TIES:
                begin
                    run_len = $urandom_range(10, 30);
                    for (int i = 0; i < run_len; i++)
                        send_price(31'($urandom_range(0, 3)));
                end
                SHAPE_ZIGZAG:
                begin
                    run_len = $urandom_range(10, 40);
                    p = 31'($urandom()) | 31'h100;
                    for (int i = 0; i < run_len; i++)
                        send_price(p + 31'($urandom_range(0, 64)) - 31'd32);
                end
                SHAPE_NOISE:
                begin
                    // Fully random prices, with the extremes mixed in.
                    run_len = $urandom_range(1, 10);
                    for (int i = 0; i < run_len; i++)
                    begin
                        case ($urandom_range(0, 7))
                            0:       send_price(31'd0);
                            1:       send_price(PRICE_MAX);
                            default: send_price(31'($urandom()));
                        endcase
                    end
                end
                default:
                begin
                    wait_for_drain();
                    send_price(31'($urandom()));
                end
            endcase
        end

        // Wait for every expected span, then a while longer so that any
        // stray result would still be caught.
        wait_for_drain();
        repeat (SETTLE) @(posedge clk);

        $display("Summary: %0d prices sent, %0d spans checked, stack overflow %s.",
                 sent, checked, overflowed ? "reached" : "not reached");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
